// ===== rtl/core/jsu_pkg.sv =====
`timescale 1ns / 1ps
package jsu_pkg;

  localparam int unsigned JSU_DIMS  = 3;
  localparam int unsigned CFG_IDX_W = 8;

  // floor(x/3) = (x * DIV3_RECIP) >> DIV3_SHIFT, exact for x < 2**49
  localparam logic [47:0]  DIV3_RECIP = 48'd187649984473771;
  localparam int unsigned  DIV3_SHIFT = 49;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHEAR_DT  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BULK_DT   = 8'd2;

  localparam logic signed [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SAT_MIN = {1'b1, {63{1'b0}}};

  typedef struct packed {
    logic signed [47:0] rate_xx;
    logic signed [47:0] rate_yy;
    logic signed [47:0] rate_zz;
    logic signed [47:0] rate_xy;
    logic signed [47:0] rate_yz;
    logic signed [47:0] rate_xz;
    logic signed [47:0] spin_xy;
    logic signed [47:0] spin_yz;
    logic signed [47:0] spin_xz;
  } jsu_in_t;

  typedef struct packed {
    logic signed [63:0] stress_xx;
    logic signed [63:0] stress_yy;
    logic signed [63:0] stress_zz;
    logic signed [63:0] stress_xy;
    logic signed [63:0] stress_yz;
    logic signed [63:0] stress_xz;
    logic signed [63:0] pressure_out;
  } jsu_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_WAIT, ST_NEXT, ST_DONE
  } jsu_state_t;

  typedef enum logic [2:0] {
    PH_MEAN, PH_PRES, PH_CROSS, PH_SHEAR, PH_TSTEP
  } jsu_phase_t;

  // multiplier operand pair, latched on start
  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [48:0] b;
  } jsu_mul_req_t;

  typedef struct packed {
    logic         done;
    logic         neg;
    logic [111:0] mag;
  } jsu_mul_rsp_t;

  function automatic logic [1:0] row_of(input logic [2:0] n);
    unique case (n)
      3'd1, 3'd4: return 2'd1;
      3'd2:       return 2'd2;
      default:    return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] col_of(input logic [2:0] n);
    unique case (n)
      3'd1, 3'd3: return 2'd1;
      3'd2, 3'd4, 3'd5: return 2'd2;
      default:    return 2'd0;
    endcase
  endfunction

  // symmetric tensor entry to packed slot
  function automatic logic [2:0] tix(input logic [1:0] r, input logic [1:0] c);
    logic [3:0] rc;
    rc = {r, c};
    unique case (rc)
      4'b00_00: return 3'd0;
      4'b01_01: return 3'd1;
      4'b10_10: return 3'd2;
      4'b00_01, 4'b01_00: return 3'd3;
      4'b01_10, 4'b10_01: return 3'd4;
      default:  return 3'd5;
    endcase
  endfunction

  function automatic logic signed [48:0] spin_get(input jsu_in_t d,
                                                 input logic [1:0] r,
                                                 input logic [1:0] c);
    logic [3:0] rc;
    rc = {r, c};
    unique case (rc)
      4'b00_01: return 49'(d.spin_xy);
      4'b01_00: return -49'(d.spin_xy);
      4'b01_10: return 49'(d.spin_yz);
      4'b10_01: return -49'(d.spin_yz);
      4'b00_10: return 49'(d.spin_xz);
      4'b10_00: return -49'(d.spin_xz);
      default:  return '0;
    endcase
  endfunction

  function automatic logic signed [47:0] rate_get(input jsu_in_t d, input logic [2:0] n);
    unique case (n)
      3'd0:    return d.rate_xx;
      3'd1:    return d.rate_yy;
      3'd2:    return d.rate_zz;
      3'd3:    return d.rate_xy;
      3'd4:    return d.rate_yz;
      default: return d.rate_xz;
    endcase
  endfunction

  // round half up, arithmetic shift, saturate to 64 bits
  function automatic logic signed [63:0] rsh_sat(input logic signed [127:0] a,
                                                input int unsigned s);
    logic signed [127:0] t;
    logic signed [127:0] q;
    t = a + (128'sd1 <<< (s - 1));
    q = t >>> s;
    if (q[127:63] == {65{q[63]}}) return q[63:0];
    return t[127] ? SAT_MIN : SAT_MAX;
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] r;
    r = 65'(a) - 65'(b);
    if (r[64] != r[63]) return r[64] ? SAT_MIN : SAT_MAX;
    return r[63:0];
  endfunction

endpackage

// ===== rtl/core/jaumann_stress_update_unit.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake           payload
// in_       input      in_valid/in_stall   jsu_in_t (strain rate, spin)
// out_      output     out_valid/out_stall jsu_out_t (total stress, pressure)
// cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// one item takes 2 + 6*(2*DIMS + 2) products, all on one shared 32x32 multiplier
// that builds each 64x48 product from 32x32 partial products;
// the mean is a reciprocal multiply on the same unit.
// reset clears stress, pressure and gains.
// the result sits in an output register; the next item is taken while it waits,
// and the block only holds at the end of an item if that register is still full.
module jaumann_stress_update_unit #(
  parameter int unsigned DIMS = jsu_pkg::JSU_DIMS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  jsu_pkg::jsu_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output jsu_pkg::jsu_out_t                out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [jsu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [47:0]                      cfg_data
);
  import jsu_pkg::*;

  localparam int unsigned KW = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam logic [KW-1:0] K_LAST = KW'(DIMS - 1);

  jsu_state_t state_r, state_nxt;
  jsu_phase_t phase_r;
  logic [2:0]  comp_r;
  logic [KW-1:0] k_r;
  logic        half_r;
  logic        out_valid_r;
  jsu_out_t    out_r;

  logic [47:0] time_step_r, shear_dt_r, bulk_dt_r;
  logic signed [63:0] tau_r [6];
  logic signed [63:0] p_r;
  logic signed [63:0] tnew_r [6];
  logic signed [63:0] pnew_r;
  logic signed [63:0] c16_r;
  logic signed [127:0] acc_r;
  jsu_in_t     in_r;
  logic signed [49:0] tr_r;
  logic signed [49:0] mean_r;

  logic        accept;
  logic        can_load;
  logic        k_last;
  logic signed [49:0] tr_in;
  logic [49:0] tr_abs;
  logic [49:0] mean_mag;
  logic [1:0]  ri, cj, kk;
  logic [2:0]  tau_addr;
  logic signed [63:0] tau_sel;
  logic signed [63:0] op_a;
  logic signed [48:0] op_b;
  logic        op_sub;
  logic        op_sh16;
  logic        mul_start;
  jsu_mul_req_t mreq;
  jsu_mul_rsp_t mrsp;
  logic [127:0] addend;
  logic signed [127:0] acc_nxt;

  assign accept   = in_valid && !in_stall;
  assign can_load = !out_valid_r || !out_stall;
  assign k_last   = (k_r == K_LAST);
  assign tr_in    = 50'(in_data.rate_xx) + 50'(in_data.rate_yy) + 50'(in_data.rate_zz);
  assign tr_abs   = tr_r[49] ? 50'(-tr_r) : 50'(tr_r);
  assign mean_mag = 50'(mrsp.mag >> DIV3_SHIFT);

  assign ri = row_of(comp_r);
  assign cj = col_of(comp_r);
  assign kk = 2'(k_r);

  always_comb begin
    tau_addr = comp_r;
    if (state_r != ST_NEXT && phase_r == PH_CROSS)
      tau_addr = half_r ? tix(ri, kk) : tix(kk, cj);
  end

  assign tau_sel = tau_r[tau_addr];

  always_comb begin
    op_a    = '0;
    op_b    = '0;
    op_sub  = 1'b0;
    op_sh16 = 1'b0;
    unique case (phase_r)
      PH_MEAN: begin
        // (|trace| + 1) / 3 by reciprocal multiply
        op_a = signed'(64'(tr_abs) + 64'd1);
        op_b = signed'({1'b0, DIV3_RECIP});
      end
      PH_PRES: begin
        op_a   = 64'(tr_r);
        op_b   = signed'({1'b0, bulk_dt_r});
        op_sub = 1'b1;
      end
      PH_CROSS: begin
        op_a   = tau_sel;
        op_b   = half_r ? spin_get(in_r, kk, cj) : spin_get(in_r, ri, kk);
        op_sub = half_r;
      end
      PH_SHEAR: begin
        op_a    = (comp_r < 3'd3) ? 64'(rate_get(in_r, comp_r)) - 64'(mean_r)
                                  : 64'(rate_get(in_r, comp_r));
        op_b    = signed'({1'b0, shear_dt_r});
        op_sh16 = 1'b1;
      end
      PH_TSTEP: begin
        op_a = c16_r;
        op_b = signed'({1'b0, time_step_r});
      end
      default: ;
    endcase
  end

  always_comb begin
    addend  = op_sh16 ? (128'(mrsp.mag) << 16) : 128'(mrsp.mag);
    acc_nxt = (op_sub ^ mrsp.neg) ? acc_r - signed'(addend) : acc_r + signed'(addend);
  end

  assign mreq.start = mul_start;
  assign mreq.a     = op_a;
  assign mreq.b     = op_b;

  jsu_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_WAIT;
      ST_WAIT: if (mrsp.done) state_nxt = ST_NEXT;
      ST_NEXT: state_nxt = (phase_r == PH_TSTEP && comp_r == 3'd5) ? ST_DONE : ST_MUL;
      ST_DONE: if (can_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    mul_start = (state_r == ST_MUL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_MEAN;
      comp_r      <= '0;
      k_r         <= '0;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
      time_step_r <= '0;
      shear_dt_r  <= '0;
      bulk_dt_r   <= '0;
      p_r         <= '0;
      for (int n = 0; n < 6; n++) tau_r[n] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_TIME_STEP: time_step_r <= cfg_data;
          CFG_SHEAR_DT:  shear_dt_r  <= cfg_data;
          CFG_BULK_DT:   bulk_dt_r   <= cfg_data;
          default: ;
        endcase
      end
      if (accept) phase_r <= PH_MEAN;
      if (state_r == ST_NEXT) begin
        unique case (phase_r)
          PH_MEAN: phase_r <= PH_PRES;
          PH_PRES: begin
            phase_r <= PH_CROSS;
            comp_r  <= '0;
            k_r     <= '0;
            half_r  <= 1'b0;
          end
          PH_CROSS: begin
            half_r <= !half_r;
            if (half_r) begin
              if (k_last) phase_r <= PH_SHEAR;
              else k_r <= k_r + KW'(1);
            end
          end
          PH_SHEAR: phase_r <= PH_TSTEP;
          PH_TSTEP: begin
            if (comp_r != 3'd5) begin
              comp_r  <= comp_r + 3'd1;
              phase_r <= PH_CROSS;
              k_r     <= '0;
            end
          end
          default: ;
        endcase
      end
      if (state_r == ST_DONE && can_load) begin
        out_valid_r <= 1'b1;
        p_r         <= pnew_r;
        for (int n = 0; n < 6; n++) tau_r[n] <= tnew_r[n];
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
      tr_r <= tr_in;
    end
    if (state_r == ST_WAIT && mrsp.done) acc_r <= acc_nxt;
    if (state_r == ST_NEXT) begin
      unique case (phase_r)
        PH_MEAN: begin
          mean_r <= tr_r[49] ? -signed'(mean_mag) : signed'(mean_mag);
          acc_r  <= 128'(p_r) <<< 32;
        end
        PH_PRES: begin
          pnew_r <= rsh_sat(acc_r, 32);
          acc_r  <= '0;
        end
        PH_CROSS: begin
          if (half_r && k_last) begin
            c16_r <= rsh_sat(acc_r, 32);
            acc_r <= 128'(tau_sel) <<< 48;
          end
        end
        PH_TSTEP: begin
          tnew_r[comp_r] <= rsh_sat(acc_r, 48);
          acc_r          <= '0;
        end
        default: ;
      endcase
    end
    if (state_r == ST_DONE && can_load) begin
      out_r.stress_xx    <= sat_sub(tnew_r[0], pnew_r);
      out_r.stress_yy    <= sat_sub(tnew_r[1], pnew_r);
      out_r.stress_zz    <= sat_sub(tnew_r[2], pnew_r);
      out_r.stress_xy    <= tnew_r[3];
      out_r.stress_yz    <= tnew_r[4];
      out_r.stress_xz    <= tnew_r[5];
      out_r.pressure_out <= pnew_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

endmodule

// ===== rtl/core/jsu_mul.sv =====
`timescale 1ns / 1ps
module jsu_mul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  jsu_pkg::jsu_mul_req_t req,
  output jsu_pkg::jsu_mul_rsp_t rsp
);
  import jsu_pkg::*;

  logic         busy_r;
  logic         done_r;
  logic [1:0]   cnt_r;
  logic [63:0]  amag_r;
  logic [47:0]  bmag_r;
  logic         neg_r;
  logic [111:0] acc_r;
  logic [31:0]  a_chunk;
  logic [31:0]  b_chunk;
  logic [63:0]  pp;
  logic [111:0] pp_sh;

  // 32x32 partial products, one per cycle
  always_comb begin
    a_chunk = cnt_r[0] ? amag_r[63:32] : amag_r[31:0];
    b_chunk = cnt_r[1] ? {16'd0, bmag_r[47:32]} : bmag_r[31:0];
    pp      = a_chunk * b_chunk;
    unique case (cnt_r)
      2'd0:       pp_sh = 112'(pp);
      2'd1, 2'd2: pp_sh = 112'(pp) << 32;
      default:    pp_sh = 112'(pp) << 64;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      amag_r <= req.a[63] ? 64'(-req.a) : 64'(req.a);
      bmag_r <= req.b[48] ? 48'(-req.b) : 48'(req.b);
      neg_r  <= req.a[63] ^ req.b[48];
      acc_r  <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + pp_sh;
    end
  end

  assign rsp.done = done_r;
  assign rsp.neg  = neg_r;
  assign rsp.mag  = acc_r;

endmodule
